### design/lup_pkg.sv
// Shared types, constants and micro-program tables for the lens undistortion block.
package lup_pkg;

    localparam int MAX_ITERATIONS  = 20;
    localparam int COORD_FRAC_BITS = 4;
    localparam int UP_SHIFT        = 32 - COORD_FRAC_BITS;
    localparam int ITER_W          = $clog2(MAX_ITERATIONS + 1);
    localparam int DIV_W           = 64;
    localparam int DIV_CNT_W       = $clog2(DIV_W);
    localparam int MUL_W           = 26;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int STEP_W          = 6;

    localparam logic signed [23:0] QMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] QMIN = 24'sh800000;
    localparam logic signed [27:0] QONE = 28'sh0100000;
    localparam logic signed [19:0] OMAX = 20'sh7FFFF;
    localparam logic signed [19:0] OMIN = 20'sh80000;

    localparam logic [2:0] REG_FOCAL  = 3'd0;
    localparam logic [2:0] REG_CENTER = 3'd1;
    localparam logic [2:0] REG_SKEW   = 3'd2;
    localparam logic [2:0] REG_K1     = 3'd3;
    localparam logic [2:0] REG_K2     = 3'd4;
    localparam logic [2:0] REG_K3     = 3'd5;
    localparam logic [2:0] REG_P1     = 3'd6;
    localparam logic [2:0] REG_P2     = 3'd7;

    localparam logic [STEP_W-1:0] PRE_LEN  = 6'd13;
    localparam logic [STEP_W-1:0] LOOP_LEN = 6'd35;
    localparam logic [STEP_W-1:0] POST_LEN = 6'd6;

    typedef enum logic [5:0] {
        OP_NOP, OP_DIVY_GO, OP_DIVY_END, OP_M_SKDY, OP_W_SKDY, OP_DIVX_GO, OP_DIVX_END,
        OP_M_FXFX, OP_THRX_GO, OP_THRX_END, OP_M_FYFY, OP_THRY_GO, OP_THRY_END, OP_INIT,
        OP_M_XX, OP_W_X2, OP_M_YY, OP_W_Y2, OP_M_XY, OP_W_XY, OP_R2, OP_M_R4, OP_W_R4,
        OP_M_R6, OP_W_R6, OP_M_K1R2, OP_W_K1, OP_M_K2R4, OP_W_ACC, OP_M_K3R6, OP_W_RAD,
        OP_TXY, OP_M_RADX, OP_W_SET, OP_M_P1XY, OP_W_ACC2, OP_M_P2TX, OP_W_DDX,
        OP_M_RADY, OP_M_P1TY, OP_M_P2XY, OP_W_DDY, OP_EXY, OP_M_EXEX, OP_W_ERR,
        OP_M_EYEY, OP_W_UPD, OP_M_SKUY, OP_W_T, OP_M_FXT, OP_W_OX, OP_M_FYUY, OP_W_OY
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_WAIT, S_LOOP, S_CHECK, S_POST, S_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic capture;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic conv;
    } stat_t;

    typedef struct packed {
        logic [23:0]        fx;
        logic [23:0]        fy;
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic signed [17:0] alpha;
        logic signed [23:0] k1;
        logic signed [23:0] k2;
        logic signed [23:0] k3;
        logic signed [23:0] p1;
        logic signed [23:0] p2;
    } cfg_t;

    function automatic logic is_div_start(input op_t op);
        return (op == OP_DIVY_GO) || (op == OP_DIVX_GO) ||
               (op == OP_THRX_GO) || (op == OP_THRY_GO);
    endfunction

    function automatic op_t pre_op(input logic [STEP_W-1:0] step);
        case (step)
            6'd0:    return OP_DIVY_GO;
            6'd1:    return OP_DIVY_END;
            6'd2:    return OP_M_SKDY;
            6'd3:    return OP_W_SKDY;
            6'd4:    return OP_DIVX_GO;
            6'd5:    return OP_DIVX_END;
            6'd6:    return OP_M_FXFX;
            6'd7:    return OP_THRX_GO;
            6'd8:    return OP_THRX_END;
            6'd9:    return OP_M_FYFY;
            6'd10:   return OP_THRY_GO;
            6'd11:   return OP_THRY_END;
            6'd12:   return OP_INIT;
            default: return OP_NOP;
        endcase
    endfunction

    function automatic op_t loop_op(input logic [STEP_W-1:0] step);
        case (step)
            6'd0:    return OP_M_XX;
            6'd1:    return OP_W_X2;
            6'd2:    return OP_M_YY;
            6'd3:    return OP_W_Y2;
            6'd4:    return OP_M_XY;
            6'd5:    return OP_W_XY;
            6'd6:    return OP_R2;
            6'd7:    return OP_M_R4;
            6'd8:    return OP_W_R4;
            6'd9:    return OP_M_R6;
            6'd10:   return OP_W_R6;
            6'd11:   return OP_M_K1R2;
            6'd12:   return OP_W_K1;
            6'd13:   return OP_M_K2R4;
            6'd14:   return OP_W_ACC;
            6'd15:   return OP_M_K3R6;
            6'd16:   return OP_W_RAD;
            6'd17:   return OP_TXY;
            6'd18:   return OP_M_RADX;
            6'd19:   return OP_W_SET;
            6'd20:   return OP_M_P1XY;
            6'd21:   return OP_W_ACC2;
            6'd22:   return OP_M_P2TX;
            6'd23:   return OP_W_DDX;
            6'd24:   return OP_M_RADY;
            6'd25:   return OP_W_SET;
            6'd26:   return OP_M_P1TY;
            6'd27:   return OP_W_ACC;
            6'd28:   return OP_M_P2XY;
            6'd29:   return OP_W_DDY;
            6'd30:   return OP_EXY;
            6'd31:   return OP_M_EXEX;
            6'd32:   return OP_W_ERR;
            6'd33:   return OP_M_EYEY;
            6'd34:   return OP_W_UPD;
            default: return OP_NOP;
        endcase
    endfunction

    function automatic op_t post_op(input logic [STEP_W-1:0] step);
        case (step)
            6'd0:    return OP_M_SKUY;
            6'd1:    return OP_W_T;
            6'd2:    return OP_M_FXT;
            6'd3:    return OP_W_OX;
            6'd4:    return OP_M_FYUY;
            6'd5:    return OP_W_OY;
            default: return OP_NOP;
        endcase
    endfunction

endpackage

### design/lens_undistort_pixel.sv
// Top level of the lens undistortion block: register port, controller and datapath.
// One pixel position is taken per transfer and its undistorted position is returned in one
// result transfer. The block works on one pixel at a time, and the time an item takes grows
// with n (1 to 20), the number of refinement iterations. It is set by the single shared
// multiplier, which each iteration uses sixteen times, and by the bit-serial divider, which
// makes four divisions per pixel (two normalisations and two threshold terms). A finished
// result waits in an output register, so the next pixel may be taken while it is still held.
// not_converged travels in m_tuser.
module lens_undistort_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_x [15:0], pixel_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // corrected_x [19:0], corrected_y [39:20]
    output logic        m_tuser,   // not_converged [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lup_pkg::*;

    cfg_t               cfg_reg;
    cmd_t               cmd;
    stat_t              stat;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic signed [19:0] corrected_x, corrected_y;
    logic               not_converged;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fx    <= 24'd4096;
            cfg_reg.fy    <= 24'd4096;
            cfg_reg.cx    <= '0;
            cfg_reg.cy    <= '0;
            cfg_reg.alpha <= '0;
            cfg_reg.k1    <= '0;
            cfg_reg.k2    <= '0;
            cfg_reg.k3    <= '0;
            cfg_reg.p1    <= '0;
            cfg_reg.p2    <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FOCAL:
                begin
                    cfg_reg.fx <= pwdata[47:24];
                    cfg_reg.fy <= pwdata[23:0];
                end
                REG_CENTER:
                begin
                    cfg_reg.cx <= pwdata[31:16];
                    cfg_reg.cy <= pwdata[15:0];
                end
                REG_SKEW: cfg_reg.alpha <= pwdata[17:0];
                REG_K1:   cfg_reg.k1    <= pwdata[23:0];
                REG_K2:   cfg_reg.k2    <= pwdata[23:0];
                REG_K3:   cfg_reg.k3    <= pwdata[23:0];
                REG_P1:   cfg_reg.p1    <= pwdata[23:0];
                REG_P2:   cfg_reg.p2    <= pwdata[23:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FOCAL:  prdata = {16'd0, cfg_reg.fx, cfg_reg.fy};
            REG_CENTER: prdata = {32'd0, cfg_reg.cx, cfg_reg.cy};
            REG_SKEW:   prdata = {46'd0, cfg_reg.alpha};
            REG_K1:     prdata = {40'd0, cfg_reg.k1};
            REG_K2:     prdata = {40'd0, cfg_reg.k2};
            REG_K3:     prdata = {40'd0, cfg_reg.k3};
            REG_P1:     prdata = {40'd0, cfg_reg.p1};
            REG_P2:     prdata = {40'd0, cfg_reg.p2};
            default:    prdata = '0;
        endcase
    end

    lup_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lup_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .pixel_x       (s_tdata[15:0]),
        .pixel_y       (s_tdata[31:16]),
        .stat          (stat),
        .corrected_x   (corrected_x),
        .corrected_y   (corrected_y),
        .not_converged (not_converged)
    );

    assign m_tdata = {corrected_y, corrected_x};
    assign m_tuser = not_converged;

    // Once a pixel is taken the block is busy until its work is done.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a transfer");

    // The divider cannot report completion in the cycle after it is started.
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        is_div_start(cmd.op) |=> !stat.div_done)
        else $error("divider finished too early");

    // A new result is only loaded when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");
endmodule

### design/lup_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lup_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lup_pkg::DIV_W-1:0] dividend,
    input  logic [lup_pkg::DIV_W-1:0] divisor,
    output logic [lup_pkg::DIV_W-1:0] quotient,
    output logic                      done
);
    import lup_pkg::*;

    logic [DIV_W:0]       rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

### design/lup_datapath.sv
// Datapath: operand registers, shared multiplier, adders and the divider.
module lup_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lup_pkg::cmd_t       cmd,
    input  lup_pkg::cfg_t       cfg,
    input  logic [15:0]         pixel_x,
    input  logic [15:0]         pixel_y,
    output lup_pkg::stat_t      stat,
    output logic signed [19:0]  corrected_x,
    output logic signed [19:0]  corrected_y,
    output logic                not_converged
);
    import lup_pkg::*;

    function automatic logic signed [23:0] sat_q(input logic signed [63:0] v);
        if (v > 64'(QMAX))
            return QMAX;
        else if (v < 64'(QMIN))
            return QMIN;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [19:0] sat_o(input logic signed [63:0] v);
        if (v > 64'(OMAX))
            return OMAX;
        else if (v < 64'(OMIN))
            return OMIN;
        else
            return v[19:0];
    endfunction

    function automatic logic signed [63:0] rshr(input logic signed [PROD_W-1:0] p,
                                                input int s);
        logic signed [63:0] w;
        w = 64'(p) + (64'sd1 <<< (s - 1));
        return w >>> s;
    endfunction

    logic [15:0]               px_reg, py_reg;
    logic signed [23:0]        dx_reg, dy_reg, ux_reg, uy_reg, tmp_reg;
    logic signed [23:0]        x2_reg, y2_reg, xy_reg, r2_reg, r4_reg, r6_reg, rad_reg;
    logic signed [23:0]        tx_reg, ty_reg, ddx_reg, ddy_reg, t_reg;
    logic signed [24:0]        ex_reg, ey_reg;
    logic signed [27:0]        acc_reg;
    logic [63:0]               thr_reg, err_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [19:0]        ox_reg, oy_reg;
    logic signed [19:0]        out_x_reg, out_y_reg;
    logic                      out_nc_reg;
    logic                      conv_reg;
    logic                      sign_reg;

    logic [23:0]               fx_e, fy_e;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [23:0]        qp20, qp16;
    logic signed [16:0]        num;
    logic [16:0]               num_mag;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend, div_divisor, div_q, f2;
    logic                      div_done;
    logic signed [63:0]        q_signed;
    logic [63:0]               err_next;

    // A zero focal length is taken as one LSB.
    assign fx_e = (cfg.fx == 24'd0) ? 24'd1 : cfg.fx;
    assign fy_e = (cfg.fy == 24'd0) ? 24'd1 : cfg.fy;

    assign qp20     = sat_q(rshr(prod_reg, 20));
    assign qp16     = sat_q(rshr(prod_reg, 16));
    assign q_signed = sign_reg ? -$signed(div_q) : $signed(div_q);
    assign err_next = err_reg + 64'(prod_reg[49:0]);
    assign f2       = 64'(prod_reg[47:0]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_M_SKDY:  begin mul_a = MUL_W'(cfg.alpha); mul_b = MUL_W'(dy_reg); end
            OP_M_FXFX:  begin mul_a = $signed({2'b00, fx_e}); mul_b = $signed({2'b00, fx_e}); end
            OP_M_FYFY:  begin mul_a = $signed({2'b00, fy_e}); mul_b = $signed({2'b00, fy_e}); end
            OP_M_XX:    begin mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(ux_reg); end
            OP_M_YY:    begin mul_a = MUL_W'(uy_reg); mul_b = MUL_W'(uy_reg); end
            OP_M_XY:    begin mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(uy_reg); end
            OP_M_R4:    begin mul_a = MUL_W'(r2_reg); mul_b = MUL_W'(r2_reg); end
            OP_M_R6:    begin mul_a = MUL_W'(r4_reg); mul_b = MUL_W'(r2_reg); end
            OP_M_K1R2:  begin mul_a = MUL_W'(cfg.k1); mul_b = MUL_W'(r2_reg); end
            OP_M_K2R4:  begin mul_a = MUL_W'(cfg.k2); mul_b = MUL_W'(r4_reg); end
            OP_M_K3R6:  begin mul_a = MUL_W'(cfg.k3); mul_b = MUL_W'(r6_reg); end
            OP_M_RADX:  begin mul_a = MUL_W'(rad_reg); mul_b = MUL_W'(ux_reg); end
            OP_M_P1XY:  begin mul_a = MUL_W'(cfg.p1); mul_b = MUL_W'(xy_reg); end
            OP_M_P2TX:  begin mul_a = MUL_W'(cfg.p2); mul_b = MUL_W'(tx_reg); end
            OP_M_RADY:  begin mul_a = MUL_W'(rad_reg); mul_b = MUL_W'(uy_reg); end
            OP_M_P1TY:  begin mul_a = MUL_W'(cfg.p1); mul_b = MUL_W'(ty_reg); end
            OP_M_P2XY:  begin mul_a = MUL_W'(cfg.p2); mul_b = MUL_W'(xy_reg); end
            OP_M_EXEX:  begin mul_a = MUL_W'(ex_reg); mul_b = MUL_W'(ex_reg); end
            OP_M_EYEY:  begin mul_a = MUL_W'(ey_reg); mul_b = MUL_W'(ey_reg); end
            OP_M_SKUY:  begin mul_a = MUL_W'(cfg.alpha); mul_b = MUL_W'(uy_reg); end
            OP_M_FXT:   begin mul_a = $signed({2'b00, fx_e}); mul_b = MUL_W'(t_reg); end
            OP_M_FYUY:  begin mul_a = $signed({2'b00, fy_e}); mul_b = MUL_W'(uy_reg); end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Numerator of the normalising division, as sign and magnitude.
    always_comb
    begin
        if (cmd.op == OP_DIVY_GO)
            num = $signed({1'b0, py_reg}) - $signed({1'b0, cfg.cy});
        else
            num = $signed({1'b0, px_reg}) - $signed({1'b0, cfg.cx});
        num_mag = num[16] ? 17'(-num) : 17'(num);
    end

    always_comb
    begin
        div_start    = is_div_start(cmd.op);
        div_dividend = 64'(num_mag) << UP_SHIFT;
        div_divisor  = 64'(fx_e);
        case (cmd.op)
            OP_DIVY_GO: div_divisor = 64'(fy_e);
            OP_THRX_GO,
            OP_THRY_GO:
            begin
                div_dividend = '1;
                div_divisor  = (f2 << 6) + (f2 << 5) + (f2 << 2);
            end
            default: div_divisor = 64'(fx_e);
        endcase
    end

    lup_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.load_out)
        begin
            out_x_reg  <= ox_reg;
            out_y_reg  <= oy_reg;
            out_nc_reg <= !conv_reg;
        end
        case (cmd.op)
            OP_DIVY_GO,
            OP_DIVX_GO:  sign_reg <= num[16];
            OP_DIVY_END: dy_reg   <= sat_q(q_signed);
            OP_W_SKDY:   tmp_reg  <= qp16;
            OP_DIVX_END: dx_reg   <= sat_q(q_signed - 64'(tmp_reg));
            OP_THRX_END: thr_reg  <= div_q;
            OP_THRY_END: thr_reg  <= thr_reg + div_q;
            OP_INIT:
            begin
                ux_reg <= dx_reg;
                uy_reg <= dy_reg;
            end
            OP_W_X2:     x2_reg  <= qp20;
            OP_W_Y2:     y2_reg  <= qp20;
            OP_W_XY:     xy_reg  <= qp20;
            OP_R2:       r2_reg  <= sat_q(64'(x2_reg) + 64'(y2_reg));
            OP_W_R4:     r4_reg  <= qp20;
            OP_W_R6:     r6_reg  <= qp20;
            OP_W_K1:     acc_reg <= QONE + 28'(qp20);
            OP_W_ACC:    acc_reg <= acc_reg + 28'(qp20);
            OP_W_RAD:    rad_reg <= sat_q(64'(acc_reg) + 64'(qp20));
            OP_TXY:
            begin
                tx_reg <= sat_q(64'(r2_reg) + (64'(x2_reg) <<< 1));
                ty_reg <= sat_q(64'(r2_reg) + (64'(y2_reg) <<< 1));
            end
            OP_W_SET:    acc_reg <= 28'(qp20);
            OP_W_ACC2:   acc_reg <= acc_reg + (28'(qp20) <<< 1);
            OP_W_DDX:    ddx_reg <= sat_q(64'(acc_reg) + 64'(qp20));
            OP_W_DDY:    ddy_reg <= sat_q(64'(acc_reg) + (64'(qp20) <<< 1));
            OP_EXY:
            begin
                ex_reg <= 25'(ddx_reg) - 25'(dx_reg);
                ey_reg <= 25'(ddy_reg) - 25'(dy_reg);
            end
            OP_W_ERR:    err_reg <= 64'(prod_reg[49:0]);
            OP_W_UPD:
            begin
                // The guess moves before the residual test takes effect.
                conv_reg <= err_next < thr_reg;
                ux_reg   <= sat_q(64'(ux_reg) - 64'(ex_reg));
                uy_reg   <= sat_q(64'(uy_reg) - 64'(ey_reg));
            end
            OP_W_T:      t_reg  <= sat_q(64'(ux_reg) + 64'(qp16));
            OP_W_OX:     ox_reg <= sat_o(rshr(prod_reg, UP_SHIFT) + 64'($signed({1'b0, cfg.cx})));
            OP_W_OY:     oy_reg <= sat_o(rshr(prod_reg, UP_SHIFT) + 64'($signed({1'b0, cfg.cy})));
            default:     ;
        endcase
    end

    assign stat.div_done  = div_done;
    assign stat.conv      = conv_reg;
    assign corrected_x    = out_x_reg;
    assign corrected_y    = out_y_reg;
    assign not_converged  = out_nc_reg;
endmodule

### design/lup_ctrl.sv
// Controller: sequences the micro-operations and owns the stream handshakes.
module lup_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  lup_pkg::stat_t stat,
    output lup_pkg::cmd_t  cmd
);
    import lup_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        iter_next    = iter_reg;
        s_tready     = 1'b0;
        cmd.op       = OP_NOP;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.op    = pre_op(step_reg);
                step_next = step_reg + 1'b1;
                if (is_div_start(cmd.op))
                    state_next = S_WAIT;
                else if (step_reg == PRE_LEN - 1'b1)
                begin
                    step_next  = '0;
                    iter_next  = '0;
                    state_next = S_LOOP;
                end
            end
            S_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_PRE;
            end
            S_LOOP:
            begin
                cmd.op    = loop_op(step_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == LOOP_LEN - 1'b1)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                step_next = '0;
                iter_next = iter_reg + 1'b1;
                if (stat.conv || (iter_reg == ITER_W'(MAX_ITERATIONS - 1)))
                    state_next = S_POST;
                else
                    state_next = S_LOOP;
            end
            S_POST:
            begin
                cmd.op    = post_op(step_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == POST_LEN - 1'b1)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;
endmodule

### verif/tb_lens_undistort_pixel.sv
// Testbench for lens_undistort_pixel: directed and random pixels checked against a fixed-point predictor.
module tb_lens_undistort_pixel;
    import lup_pkg::*;

    localparam longint SAT_HI = 64'sd8388607;
    localparam longint SAT_LO = -64'sd8388608;
    localparam longint ONE_Q  = 64'sd1048576;
    localparam int     PHASES = 12;
    localparam int     PHASE_ITEMS = 42;

    typedef struct {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic               nc;
    } corr_t;

    typedef struct {
        logic [15:0]        px;
        logic [15:0]        py;
        bit                 typed;
        logic signed [19:0] ex;
        logic signed [19:0] ey;
        logic               en;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // pixel_x [15:0], pixel_y [31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // corrected_x [19:0], corrected_y [39:20]
    logic        m_tuser;   // not_converged [0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    corr_t       pending_corr[$];
    logic [63:0] reg_shadow[8];
    int          errors;
    int          idle_mode;
    int          hold_cycles;

    lens_undistort_pixel u_dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clampq(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_down(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return clampq(round_down(a * b, 20), SAT_LO, SAT_HI);
    endfunction

    function automatic longint skew_term(input longint y);
        longint alpha;
        alpha = longint'(signed'(reg_shadow[REG_SKEW][17:0]));
        return clampq(round_down(alpha * y, 16), SAT_LO, SAT_HI);
    endfunction

    function automatic longint coef(input logic [2:0] idx);
        return longint'(signed'(reg_shadow[idx][23:0]));
    endfunction

    function automatic void lens_distort(input longint x, input longint y,
                                         output longint xd, output longint yd);
        longint x2, y2, xy, r2, r4, r6, rad, tx, ty;
        x2  = fmul(x, x);
        y2  = fmul(y, y);
        xy  = fmul(x, y);
        r2  = clampq(x2 + y2, SAT_LO, SAT_HI);
        r4  = fmul(r2, r2);
        r6  = fmul(r4, r2);
        rad = clampq(ONE_Q + fmul(coef(REG_K1), r2) + fmul(coef(REG_K2), r4)
                     + fmul(coef(REG_K3), r6), SAT_LO, SAT_HI);
        tx  = clampq(r2 + 2 * x2, SAT_LO, SAT_HI);
        ty  = clampq(r2 + 2 * y2, SAT_LO, SAT_HI);
        xd  = clampq(fmul(rad, x) + 2 * fmul(coef(REG_P1), xy) + fmul(coef(REG_P2), tx),
                     SAT_LO, SAT_HI);
        yd  = clampq(fmul(rad, y) + fmul(coef(REG_P1), ty) + 2 * fmul(coef(REG_P2), xy),
                     SAT_LO, SAT_HI);
    endfunction

    function automatic corr_t undistort(input logic [15:0] px, input logic [15:0] py);
        longint fx, fy, cx, cy, dx, dy, ux, uy, ddx, ddy, ex, ey, t;
        longint unsigned thr, err;
        bit    done;
        corr_t r;
        fx = longint'(reg_shadow[REG_FOCAL][47:24]);
        fy = longint'(reg_shadow[REG_FOCAL][23:0]);
        cx = longint'(reg_shadow[REG_CENTER][31:16]);
        cy = longint'(reg_shadow[REG_CENTER][15:0]);
        if (fx == 0) fx = 1;
        if (fy == 0) fy = 1;
        dy = clampq(((longint'(py) - cy) * (64'sd1 <<< UP_SHIFT)) / fy, SAT_LO, SAT_HI);
        dx = clampq(((longint'(px) - cx) * (64'sd1 <<< UP_SHIFT)) / fx - skew_term(dy),
                    SAT_LO, SAT_HI);
        thr = 64'hFFFF_FFFF_FFFF_FFFF / (64'd100 * longint'(unsigned'(fx * fx)))
            + 64'hFFFF_FFFF_FFFF_FFFF / (64'd100 * longint'(unsigned'(fy * fy)));
        ux = dx;
        uy = dy;
        done = 1'b0;
        for (int it = 0; it < MAX_ITERATIONS && !done; it++)
        begin
            lens_distort(ux, uy, ddx, ddy);
            ex  = ddx - dx;
            ey  = ddy - dy;
            err = longint'(unsigned'(ex * ex)) + longint'(unsigned'(ey * ey));
            ux  = clampq(ux - ex, SAT_LO, SAT_HI);
            uy  = clampq(uy - ey, SAT_LO, SAT_HI);
            if (err < thr)
                done = 1'b1;
        end
        t    = clampq(ux + skew_term(uy), SAT_LO, SAT_HI);
        r.cx = 20'(clampq(round_down(fx * t, UP_SHIFT) + cx, -64'sd524288, 64'sd524287));
        r.cy = 20'(clampq(round_down(fy * uy, UP_SHIFT) + cy, -64'sd524288, 64'sd524287));
        r.nc = !done;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_shadow[idx] = value;
    endtask

    // Offers one pixel and waits for its transfer; the predicted result is queued at acceptance.
    task automatic send_pixel(input logic [15:0] px, input logic [15:0] py, input bit typed,
                              input corr_t typed_res);
        int idle_pct;
        idle_pct = (idle_mode == 3) ? 29 : 63;
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do
            @(posedge clk);
        while (!s_tready);
        pending_corr.push_back(typed ? typed_res : undistort(px, py));
        if ((idle_mode == 1 || idle_mode == 3) && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
            @(posedge clk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_corr.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coef(input int span);
        return 24'($signed($urandom_range(2 * span)) - span);
    endfunction

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else if (idle_mode >= 2)
            m_tready <= ($urandom_range(99) >= ((idle_mode == 3) ? 29 : 63));
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        corr_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_corr.size() == 0)
            begin
                $display("MISMATCH unexpected result transfer at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_corr.pop_front();
                if (m_tdata[19:0] !== want.cx)
                    report_mismatch("corrected_x", signed'(m_tdata[19:0]), want.cx);
                if (m_tdata[39:20] !== want.cy)
                    report_mismatch("corrected_y", signed'(m_tdata[39:20]), want.cy);
                if (m_tuser !== want.nc)
                    report_mismatch("not_converged", m_tuser, want.nc);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        row_t  rows[$];
        corr_t tr;
        corr_t none;
        logic [15:0] px, py;

        errors      = 0;
        idle_mode   = 0;
        hold_cycles = 0;
        none        = '{cx: '0, cy: '0, nc: 1'b0};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        reg_shadow[REG_FOCAL] = {16'd0, 24'd4096, 24'd4096};
        for (int i = 1; i < 8; i++)
            reg_shadow[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings give unit focal lengths and no distortion, so results read off directly but for saturation.
        rows = '{
            '{16'd0,     16'd0,     1'b1, 20'sd0,   20'sd0,   1'b0},
            '{16'd1,     16'd1,     1'b1, 20'sd1,   20'sd1,   1'b0},
            '{16'd16,    16'd16,    1'b1, 20'sd16,  20'sd16,  1'b0},
            '{16'd65535, 16'd65535, 1'b1, 20'sd128, 20'sd128, 1'b0},
            '{16'd65535, 16'd0,     1'b1, 20'sd128, 20'sd0,   1'b0},
            '{16'd0,     16'd65535, 1'b1, 20'sd0,   20'sd128, 1'b0},
            '{16'h5555,  16'hAAAA,  1'b0, 20'sd0,   20'sd0,   1'b0},
            '{16'hAAAA,  16'h5555,  1'b0, 20'sd0,   20'sd0,   1'b0},
            '{16'd127,   16'd128,   1'b0, 20'sd0,   20'sd0,   1'b0}
        };
        foreach (rows[i])
        begin
            tr = '{cx: rows[i].ex, cy: rows[i].ey, nc: rows[i].en};
            send_pixel(rows[i].px, rows[i].py, rows[i].typed, tr);
        end
        drain();

        for (int ph = 1; ph <= PHASES; ph++)
        begin
            idle_mode = ph % 4;
            if (ph == 1)
            begin
                // Every register at its upper limit.
                write_reg(REG_FOCAL, 64'hFFFF_FFFF_FFFF);
                write_reg(REG_CENTER, 64'hFFFF_FFFF);
                write_reg(REG_SKEW, 64'h1FFFF);
                for (int r = REG_K1; r <= REG_P2; r++)
                    write_reg(3'(r), 64'h7FFFFF);
            end
            else if (ph == 2)
            begin
                // Zero focal lengths stand for one LSB; coefficients at their lower limit.
                write_reg(REG_FOCAL, 64'd0);
                write_reg(REG_CENTER, 64'd0);
                write_reg(REG_SKEW, 64'h20000);
                for (int r = REG_K1; r <= REG_P2; r++)
                    write_reg(3'(r), 64'h800000);
            end
            else
            begin
                write_reg(REG_FOCAL, {16'd0, 24'($urandom_range(200, 3000) * 4096
                                           + $urandom_range(4095)),
                                      (ph == 3) ? 24'd0 : 24'($urandom_range(200, 3000) * 4096)});
                write_reg(REG_CENTER, {32'd0, 16'($urandom_range(32000)),
                                       16'($urandom_range(32000))});
                write_reg(REG_SKEW, {46'd0, 18'($signed($urandom_range(2000)) - 1000)});
                write_reg(REG_K1, {40'd0, rand_coef(ph > 8 ? 1500000 : 400000)});
                write_reg(REG_K2, {40'd0, rand_coef(200000)});
                write_reg(REG_K3, {40'd0, rand_coef(100000)});
                write_reg(REG_P1, {40'd0, rand_coef(ph > 8 ? 200000 : 5000)});
                write_reg(REG_P2, {40'd0, rand_coef(ph > 8 ? 200000 : 5000)});
            end
            if (ph == 5)
                hold_cycles = 3000;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(2) == 0)
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                else
                begin
                    // Mostly near the optical centre, where the iteration behaves.
                    px = 16'(reg_shadow[REG_CENTER][31:16] + $urandom_range(8000) - 4000);
                    py = 16'(reg_shadow[REG_CENTER][15:0] + $urandom_range(8000) - 4000);
                end
                send_pixel(px, py, 1'b0, none);
                if (ph == 6 && n == PHASE_ITEMS / 2)
                    drain();
            end
            drain();
        end

        repeat (1100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
design/lup_pkg.sv
design/lup_div.sv
design/lup_datapath.sv
design/lup_ctrl.sv
design/lens_undistort_pixel.sv
verif/tb_lens_undistort_pixel.sv
